// ----- sv/sdts_pkg.sv -----
// ----------------------------------------------------------------------------
// sdts_pkg: shared types and constants
// beat layouts, opcodes, status codes and sizes for the sorted table
// ----------------------------------------------------------------------------
package sdts_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TOTAL  = 2'd1,
    OP_PARITY = 2'd2,
    OP_DUMP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [VAL_W-1:0]   new_value;
    logic               parity_select;
  } in_beat_t;

  typedef struct packed {
    logic [SUM_W-1:0]   result_value;
    status_e            status;
    logic               last_flag;
  } out_beat_t;

  // control broadcast to every cell
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic [VAL_W-1:0]   new_value;
  } cell_ctl_t;

endpackage

// ----- sv/sdts_cell.sv -----
// ----------------------------------------------------------------------------
// sdts_cell: one slot of the sorted table
// compares against the insert value and takes its own, the neighbor's or the
// new value on insert; rotates toward the head during a dump
// ----------------------------------------------------------------------------
module sdts_cell (
  input  logic                      clk_i,
  input  sdts_pkg::cell_ctl_t       ctl_i,
  input  logic                      occupied_i,
  input  logic                      is_tail_i,
  input  logic                      prev_gt_i,
  input  logic [sdts_pkg::VAL_W-1:0] prev_val_i,
  input  logic [sdts_pkg::VAL_W-1:0] next_val_i,
  input  logic [sdts_pkg::VAL_W-1:0] head_val_i,
  output logic                      gt_o,
  output logic [sdts_pkg::VAL_W-1:0] val_o
);

  logic [sdts_pkg::VAL_W-1:0] val_q, val_d;

  // stored entry strictly above the incoming value
  assign gt_o  = occupied_i && (val_q > ctl_i.new_value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert) begin
      if (!gt_o) begin
        val_d = prev_gt_i ? ctl_i.new_value : prev_val_i;
      end
    end else if (ctl_i.shift) begin
      val_d = is_tail_i ? head_val_i : next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- sv/sorted_descending_table_with_sums.sv -----
// ----------------------------------------------------------------------------
// sorted_descending_table_with_sums: descending table with running sums
// a chain of cells keeps the entries in order; sums and dump sequencing here
// ----------------------------------------------------------------------------
// result: registered in the cycle after an accepted beat; dump entries from S_DUMP
// insert and sums: one beat per cycle while the output is taken
// dump: one entry per cycle out of the head cell while the output is taken, input
//   stalled from the dump beat until the final entry is loaded
// reset: clears entry count, sums, sequencer and output valid; cells hold
//   unwritten data until inserts fill them
module sorted_descending_table_with_sums (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sdts_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdts_pkg::out_beat_t  out_data_o
);

  localparam int unsigned D = sdts_pkg::TABLE_DEPTH;

  // control state
  sdts_pkg::state_e             state_q, state_d;
  logic [sdts_pkg::CNT_W-1:0]   count_q, count_d;
  logic [sdts_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [sdts_pkg::SUM_W-1:0]   even_sum_q, even_sum_d;
  logic [sdts_pkg::SUM_W-1:0]   odd_sum_q, odd_sum_d;
  logic                         out_valid_q, out_valid_d;
  sdts_pkg::out_beat_t          out_q, out_d;

  // cell chain wiring
  sdts_pkg::cell_ctl_t          ctl;
  logic [D-1:0]                 gt;
  logic [sdts_pkg::VAL_W-1:0]   val [D];

  logic out_free;
  logic accept;
  logic full;
  logic dump_last;
  logic [sdts_pkg::SUM_W-1:0]   new_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sdts_pkg::S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == sdts_pkg::CNT_W'(D));
  assign new_ext    = sdts_pkg::SUM_W'(in_data_i.new_value);
  // head entry is the final one of the dump when idx reaches count - 1
  assign dump_last  = ((sdts_pkg::CNT_W'(idx_q) + sdts_pkg::CNT_W'(1)) == count_q);

  assign ctl.insert    = accept && (in_data_i.opcode == sdts_pkg::OP_INSERT) && !full;
  assign ctl.shift     = (state_q == sdts_pkg::S_DUMP) && out_free;
  assign ctl.new_value = in_data_i.new_value;

  // chain: insert flows from head to tail, dump rotates toward the head
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                       prev_gt;
    logic [sdts_pkg::VAL_W-1:0] prev_val;
    logic [sdts_pkg::VAL_W-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b1;
      assign prev_val = in_data_i.new_value;
    end else begin : g_body
      assign prev_gt  = gt[i-1];
      assign prev_val = val[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign next_val = val[0];
    end else begin : g_next
      assign next_val = val[i+1];
    end

    sdts_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occupied_i (sdts_pkg::CNT_W'(i) < count_q),
      .is_tail_i  ((sdts_pkg::CNT_W'(i) + sdts_pkg::CNT_W'(1)) == count_q),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .head_val_i (val[0]),
      .gt_o       (gt[i]),
      .val_o      (val[i])
    );
  end

  // sequencer, sums and output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    even_sum_d  = even_sum_q;
    odd_sum_d   = odd_sum_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // result taken, slot empties unless refilled below
    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_d.result_value = '0;
      out_d.status       = sdts_pkg::STAT_OK;
      out_d.last_flag    = 1'b1;
      out_valid_d        = 1'b1;
      case (in_data_i.opcode)
        sdts_pkg::OP_INSERT: begin
          if (full) begin
            out_d.status = sdts_pkg::STAT_FULL;
          end else begin
            count_d = count_q + sdts_pkg::CNT_W'(1);
            if (in_data_i.new_value[0]) begin
              odd_sum_d = odd_sum_q + new_ext;
            end else begin
              even_sum_d = even_sum_q + new_ext;
            end
          end
        end
        sdts_pkg::OP_TOTAL: begin
          out_d.result_value = even_sum_q + odd_sum_q;
        end
        sdts_pkg::OP_PARITY: begin
          out_d.result_value = in_data_i.parity_select ? even_sum_q : odd_sum_q;
        end
        sdts_pkg::OP_DUMP: begin
          if (count_q == '0) begin
            out_d.status = sdts_pkg::STAT_EMPTY;
          end else begin
            // entries stream from the dump state
            out_valid_d = 1'b0;
            idx_d       = '0;
            state_d     = sdts_pkg::S_DUMP;
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end else if (ctl.shift) begin
      out_valid_d        = 1'b1;
      out_d.result_value = sdts_pkg::SUM_W'(val[0]);
      out_d.status       = sdts_pkg::STAT_OK;
      out_d.last_flag    = dump_last;
      idx_d              = idx_q + sdts_pkg::IDX_W'(1);
      if (dump_last) begin
        state_d = sdts_pkg::S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdts_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      even_sum_q  <= '0;
      odd_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      even_sum_q  <= even_sum_d;
      odd_sum_q   <= odd_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/sorted_descending_table_with_sums_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_descending_table_with_sums_tb: self-checking bench for the sorted table
// drives insert, sum and dump beats with random gaps and output stalls; a local
// copy of the table and its sums predicts every result beat, compared in order
// ----------------------------------------------------------------------------
module sorted_descending_table_with_sums_tb;

  localparam int unsigned RANDOM_ITEMS = 100;
  // worst case is roughly 120 beats x 32 results, each result held by an output stall
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX   = 30;

  // canned results for rows whose answer is obvious
  localparam sdts_pkg::out_beat_t ZERO_OK    = '{'0, sdts_pkg::STAT_OK, 1'b1};
  localparam sdts_pkg::out_beat_t EMPTY_DUMP = '{'0, sdts_pkg::STAT_EMPTY, 1'b1};
  localparam sdts_pkg::out_beat_t NOT_TYPED  = '{'0, sdts_pkg::STAT_OK, 1'b0};

  typedef struct {
    sdts_pkg::in_beat_t  beat;
    bit                  known_valid;
    sdts_pkg::out_beat_t known;
  } directed_row_t;

  localparam int unsigned N_DIRECTED = 20;

  // opening sequence: empty-table queries, value extremes, duplicates, every
  // opcode, and unused fields carrying noise
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{sdts_pkg::OP_TOTAL,  31'd0,        1'b0}, 1'b1, ZERO_OK},    // total of empty table
    '{'{sdts_pkg::OP_PARITY, 31'd0,        1'b1}, 1'b1, ZERO_OK},    // even sum, empty table
    '{'{sdts_pkg::OP_PARITY, 31'h7fffffff, 1'b0}, 1'b1, ZERO_OK},    // odd sum, empty table
    '{'{sdts_pkg::OP_DUMP,   31'd0,        1'b0}, 1'b1, EMPTY_DUMP}, // dump of empty table
    '{'{sdts_pkg::OP_INSERT, 31'h7fffffff, 1'b0}, 1'b1, ZERO_OK},    // largest value
    '{'{sdts_pkg::OP_INSERT, 31'd0,        1'b1}, 1'b1, ZERO_OK},    // smallest value
    '{'{sdts_pkg::OP_INSERT, 31'd5,        1'b0}, 1'b1, ZERO_OK},
    '{'{sdts_pkg::OP_INSERT, 31'd5,        1'b1}, 1'b1, ZERO_OK},    // duplicate ahead of equal
    '{'{sdts_pkg::OP_INSERT, 31'h7ffffffe, 1'b0}, 1'b1, ZERO_OK},
    '{'{sdts_pkg::OP_INSERT, 31'd1,        1'b0}, 1'b1, ZERO_OK},
    '{'{sdts_pkg::OP_TOTAL,  31'h12345678, 1'b1}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_PARITY, 31'd0,        1'b1}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_PARITY, 31'd0,        1'b0}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_DUMP,   31'h7fffffff, 1'b1}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_INSERT, 31'h2aaaaaaa, 1'b1}, 1'b1, ZERO_OK},
    '{'{sdts_pkg::OP_INSERT, 31'h55555555, 1'b0}, 1'b1, ZERO_OK},
    '{'{sdts_pkg::OP_INSERT, 31'd0,        1'b0}, 1'b1, ZERO_OK},    // second zero, placed ahead of the first
    '{'{sdts_pkg::OP_TOTAL,  31'h7fffffff, 1'b0}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_PARITY, 31'h55555555, 1'b1}, 1'b0, NOT_TYPED},
    '{'{sdts_pkg::OP_DUMP,   31'h2aaaaaaa, 1'b0}, 1'b0, NOT_TYPED}
  };

  // dut ports, inputs known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sdts_pkg::in_beat_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sdts_pkg::out_beat_t out_data_o;

  // local image of the table and its running sums
  logic [sdts_pkg::VAL_W-1:0] table_image [sdts_pkg::TABLE_DEPTH];
  int unsigned                entry_total;
  logic [sdts_pkg::SUM_W-1:0] even_total;
  logic [sdts_pkg::SUM_W-1:0] odd_total;

  sdts_pkg::out_beat_t expected_results [$];
  sdts_pkg::out_beat_t oldest_result;

  // bookkeeping for the summary
  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned dropped_inserts;
  int unsigned dumps_sent;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // when set, both sides run back to back with no gaps and no stalls
  bit steady_phase;

  sorted_descending_table_with_sums u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sorted_descending_table_with_sums");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction: mirror of the table, pushes every result beat one item causes
  // ---------------------------------------------------------------------------
  function automatic void predict_results(input sdts_pkg::in_beat_t beat);
    sdts_pkg::out_beat_t res;
    int unsigned         pos;
    int unsigned         i;
    res = '{'0, sdts_pkg::STAT_OK, 1'b1};
    case (beat.opcode)
      sdts_pkg::OP_INSERT: begin
        if (entry_total >= sdts_pkg::TABLE_DEPTH) begin
          // full table: value dropped, state untouched
          res.status = sdts_pkg::STAT_FULL;
          dropped_inserts++;
        end else begin
          // new value lands after every strictly larger entry
          pos = 0;
          while (pos < entry_total && table_image[pos] > beat.new_value) pos++;
          for (i = entry_total; i > pos; i--) table_image[i] = table_image[i-1];
          table_image[pos] = beat.new_value;
          entry_total++;
          if (beat.new_value[0]) odd_total = odd_total + sdts_pkg::SUM_W'(beat.new_value);
          else                   even_total = even_total + sdts_pkg::SUM_W'(beat.new_value);
        end
        expected_results.push_back(res);
      end
      sdts_pkg::OP_TOTAL: begin
        res.result_value = even_total + odd_total;
        expected_results.push_back(res);
      end
      sdts_pkg::OP_PARITY: begin
        // select high picks the even entries
        res.result_value = beat.parity_select ? even_total : odd_total;
        expected_results.push_back(res);
      end
      default: begin
        if (entry_total == 0) begin
          res.status = sdts_pkg::STAT_EMPTY;
          expected_results.push_back(res);
        end else begin
          // largest first, last flag only on the final entry
          for (i = 0; i < entry_total; i++) begin
            res.result_value = sdts_pkg::SUM_W'(table_image[i]);
            res.last_flag    = (i + 1 == entry_total);
            expected_results.push_back(res);
          end
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_wait();
    return steady_phase ? 0 : $urandom_range(0, 14);
  endfunction

  // values lean toward small numbers (duplicates) and both extremes
  function automatic logic [sdts_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return sdts_pkg::VAL_W'($urandom_range(0, 15));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return sdts_pkg::VAL_W'($urandom());
    endcase
  endfunction

  // inserts dominate so the table fills, then full drops and long dumps follow
  function automatic sdts_pkg::in_beat_t random_beat();
    sdts_pkg::in_beat_t beat;
    int unsigned        pick;
    beat.new_value     = random_value();
    beat.parity_select = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 11);
    if (pick < 6)       beat.opcode = sdts_pkg::OP_INSERT;
    else if (pick < 8)  beat.opcode = sdts_pkg::OP_TOTAL;
    else if (pick < 10) beat.opcode = sdts_pkg::OP_PARITY;
    else                beat.opcode = sdts_pkg::OP_DUMP;
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: optional gap, then hold the beat until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_beat(input sdts_pkg::in_beat_t beat);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    // beat is taken at the first edge with stall low
    do @(posedge clk_i); while (in_stall_o);
    predict_results(beat);
    beats_sent++;
    if (beat.opcode == sdts_pkg::OP_DUMP) dumps_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: a fresh stall length for every result beat
  // ---------------------------------------------------------------------------
  initial begin : output_stall
    int unsigned hold;
    forever begin
      hold = pick_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  task automatic note_mismatch(input string what,
                               input logic [sdts_pkg::SUM_W-1:0] want_v,
                               input logic [sdts_pkg::SUM_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
  endtask

  // result beats are compared field by field against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result beat, value", '0, out_data_o.result_value);
      end else begin
        oldest_result = expected_results.pop_front();
        results_checked++;
        if (out_data_o.result_value !== oldest_result.result_value)
          note_mismatch("result_value", oldest_result.result_value,
                        out_data_o.result_value);
        if (out_data_o.status !== oldest_result.status)
          note_mismatch("status", sdts_pkg::SUM_W'(oldest_result.status),
                        sdts_pkg::SUM_W'(out_data_o.status));
        if (out_data_o.last_flag !== oldest_result.last_flag)
          note_mismatch("last_flag", sdts_pkg::SUM_W'(oldest_result.last_flag),
                        sdts_pkg::SUM_W'(out_data_o.last_flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    entry_total  = 0;
    even_total   = '0;
    odd_total    = '0;
    steady_phase = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, typed answers override the prediction where given
    for (n = 0; n < N_DIRECTED; n++) begin
      send_beat(directed_rows[n].beat);
      if (directed_rows[n].known_valid)
        expected_results[expected_results.size() - 1] = directed_rows[n].known;
    end

    // random part, with occasional back-to-back stretches
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) steady_phase = ($urandom_range(0, 3) == 0);
      send_beat(random_beat());
    end
    in_valid_i <= 1'b0;
    steady_phase = 1'b0;

    // drain, then keep watching for stray beats
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input beats: %0d dumps, %0d inserts dropped on a full table",
             beats_sent, dumps_sent, dropped_inserts);
    $display("checked %0d result beats; table ended with %0d entries, total %0d",
             results_checked, entry_total, even_total + odd_total);
    if (mismatch_count == 0) begin
      $display("PASS sorted_descending_table_with_sums");
    end else begin
      $display("FAIL sorted_descending_table_with_sums");
    end
    $finish;
  end

endmodule
